/* design/u8f_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package u8f_pkg;

	// byte class masks and marks
	localparam logic [7:0] ASCII_MAX = 8'h7F;
	localparam logic [7:0] MASK_2    = 8'hC0;
	localparam logic [7:0] MASK_3    = 8'hE0;
	localparam logic [7:0] MASK_4    = 8'hF0;
	localparam logic [7:0] MASK_5    = 8'hF8;
	localparam logic [7:0] CONT_MARK = 8'h80;

	// sequence lengths from a lead byte
	localparam logic [2:0] LEN_NONE  = 3'd0;
	localparam logic [2:0] LEN_ASCII = 3'd1;
	localparam logic [2:0] LEN_TWO   = 3'd2;
	localparam logic [2:0] LEN_THREE = 3'd3;
	localparam logic [2:0] LEN_FOUR  = 3'd4;

	// one kept sequence: up to four bytes and the index of its last byte
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} seq_entry_t;

	// length of the sequence a lead byte opens, none for a bad lead
	function automatic logic [2:0] lead_length(input logic [7:0] c);
		logic [2:0] len;
		if (c <= ASCII_MAX) begin
			len = LEN_ASCII;
		end else if ((c & MASK_3) == MASK_2) begin
			len = LEN_TWO;
		end else if ((c & MASK_4) == MASK_3) begin
			len = LEN_THREE;
		end else if ((c & MASK_5) == MASK_4) begin
			len = LEN_FOUR;
		end else begin
			len = LEN_NONE;
		end
		return len;
	endfunction

	// continuation byte test, 10xxxxxx
	function automatic logic is_cont(input logic [7:0] c);
		return (c & MASK_2) == CONT_MARK;
	endfunction

endpackage

`default_nettype wire

/* design/utf8_invalid_sequence_filter_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// utf-8 invalid sequence filter
// input channel: in_valid / in_ready with in_byte and end_of_text, one text byte
// per transaction. output channel: out_valid / out_ready with out_byte and
// run_last, one byte of a kept sequence per transaction; run_last marks the
// final byte of each sequence. bad leads and sequences with a bad continuation
// byte are dropped, as is a sequence cut short by end_of_text.
// throughput: one input byte per cycle unless the queue is full, and one output
// byte per cycle while out_ready is high. a kept sequence of n bytes leaves as n
// back-to-back transactions once its last byte is in; the byte rate out never
// exceeds the byte rate in, and while out_ready is high the stream runs at one
// byte per cycle. path: the input transaction that completes a sequence goes
// through the input register, then the sequence queue, into the output register
// that raises out_valid with its first byte.
// stall: while out_ready is low, finished sequences collect in a queue of
// QUEUE_DEPTH entries; when it is full the input register holds and in_ready
// drops. nothing is lost.
// reset: arst_n clears the open sequence, the queue and both valid flags.
module utf8_invalid_sequence_filter_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire  [7:0] in_byte,
	input  wire        end_of_text,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);
	import u8f_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// open sequence state
	logic [7:0] pend_q [3];
	logic [2:0] exp_len_q;
	logic [1:0] coll_q;
	logic       ok_q;

	// output register
	seq_entry_t cur_q;
	logic [1:0] idx_q;
	logic       cur_valid_q;

	logic       fifo_full;
	logic       fifo_not_empty;
	logic       fire;
	logic       emit;
	seq_entry_t emit_entry;
	seq_entry_t fifo_head;
	logic       load;
	logic       out_fire;
	logic       at_last;
	logic [2:0] lead_len;
	logic       ok_next;
	logic       seq_done;

	assign in_ready = !valid_s1 || !fifo_full;
	assign fire     = valid_s1 && !fifo_full;

	// input register, holds while the queue is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			eot_s1  <= end_of_text;
		end
	end

	// classify the byte and build the kept sequence
	always_comb begin
		lead_len   = lead_length(byte_s1);
		ok_next    = ok_q && is_cont(byte_s1);
		seq_done   = ({1'b0, coll_q} + 3'd1) >= exp_len_q;
		emit       = 1'b0;
		emit_entry = '0;
		if (exp_len_q == LEN_NONE) begin
			emit_entry.bytes[0] = byte_s1;
			emit_entry.last_idx = 2'd0;
			emit                = (lead_len == LEN_ASCII);
		end else begin
			for (int k = 0; k < 4; k++) begin
				if (k < 3 && 2'(k) < coll_q) begin
					emit_entry.bytes[k] = pend_q[k];
				end else begin
					emit_entry.bytes[k] = byte_s1;
				end
			end
			emit_entry.last_idx = coll_q;
			emit                = seq_done && ok_next;
		end
	end

	// sequence state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q <= LEN_NONE;
			coll_q    <= 2'd0;
			ok_q      <= 1'b1;
		end else if (fire) begin
			if (exp_len_q == LEN_NONE) begin
				if (lead_len >= LEN_TWO && !eot_s1) begin
					exp_len_q <= lead_len;
					coll_q    <= 2'd1;
					ok_q      <= 1'b1;
				end
			end else if (seq_done || eot_s1) begin
				exp_len_q <= LEN_NONE;
				coll_q    <= 2'd0;
				ok_q      <= 1'b1;
			end else begin
				coll_q <= coll_q + 2'd1;
				ok_q   <= ok_next;
			end
		end
	end

	// pending bytes of the open sequence
	always_ff @(posedge clk) begin
		if (fire) begin
			if (exp_len_q == LEN_NONE) begin
				pend_q[0] <= byte_s1;
			end else if (!seq_done && !eot_s1 && coll_q != 2'd3) begin
				pend_q[coll_q] <= byte_s1;
			end
		end
	end

	// queue of kept sequences
	u8f_seq_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_seq_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire && emit),
		.push_data (emit_entry),
		.full      (fifo_full),
		.pop       (load),
		.head      (fifo_head),
		.not_empty (fifo_not_empty)
	);

	// output register, walks one sequence a byte at a time
	assign at_last  = (idx_q == cur_q.last_idx);
	assign out_fire = cur_valid_q && out_ready;
	assign load     = fifo_not_empty && (!cur_valid_q || (out_fire && at_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else if (load) begin
			cur_valid_q <= 1'b1;
			idx_q       <= 2'd0;
		end else if (out_fire) begin
			if (at_last) begin
				cur_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= fifo_head;
		end
	end

	assign out_valid = cur_valid_q;
	assign out_byte  = cur_q.bytes[idx_q];
	assign run_last  = at_last;

endmodule

`default_nettype wire

/* design/u8f_seq_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module u8f_seq_fifo #(
	parameter int DEPTH = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  u8f_pkg::seq_entry_t push_data,
	output logic                full,
	input  wire                 pop,
	output u8f_pkg::seq_entry_t head,
	output logic                not_empty
);
	import u8f_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	seq_entry_t     mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* design/u8f_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module u8f_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] out_byte,
	input wire       run_last
);

	// a stalled output transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
		else $error("output changed while stalled");

	// an ascii byte always leaves as a sequence of its own
	a_ascii_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_byte[7] |-> run_last)
		else $error("ascii byte not marked last");

	// a multi-byte lead never closes a sequence
	a_lead_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_byte[7:6] == 2'b11 |-> !run_last)
		else $error("lead byte marked last");

	// bytes of one sequence follow back to back, each a continuation byte
	a_seq_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid && out_byte[7:6] == 2'b10)
		else $error("sequence broken on output");

endmodule

bind utf8_invalid_sequence_filter_unit u8f_checker u_u8f_checker (.*);

`default_nettype wire

/* bench/utf8_invalid_sequence_filter_unit_tb.sv */
`timescale 1ns / 1ps

module utf8_invalid_sequence_filter_unit_tb;
	import u8f_pkg::*;

	localparam int RAND_ITEMS = 155;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} kept_byte_t;

	// tracks the open sequence and the bytes the filter must let through
	class kept_seq_board;
		kept_byte_t kept[$];
		logic [7:0] held[3];
		logic [2:0] open_len;
		int         seen;
		logic       all_cont;
		int         fails;

		function new();
			fails = 0;
			drop_open();
		endfunction

		function void drop_open();
			held[0] = 8'h00;
			held[1] = 8'h00;
			held[2] = 8'h00;
			open_len = LEN_NONE;
			seen = 0;
			all_cont = 1'b1;
		endfunction

		// sequence length announced by a lead byte
		function logic [2:0] seq_len_of(logic [7:0] b);
			logic [2:0] n;
			casez (b)
				8'b0???????: n = LEN_ASCII;
				8'b110?????: n = LEN_TWO;
				8'b1110????: n = LEN_THREE;
				8'b11110???: n = LEN_FOUR;
				default:     n = LEN_NONE;
			endcase
			return n;
		endfunction

		function void push_kept(logic [7:0] b, logic l);
			kept_byte_t e;
			e.data = b;
			e.last = l;
			kept.push_back(e);
		endfunction

		// one accepted input transaction
		function void take_byte(logic [7:0] b, logic eot);
			logic [2:0] lead;
			lead = seq_len_of(b);
			if (open_len == LEN_NONE) begin
				if (lead == LEN_ASCII) begin
					push_kept(b, 1'b1);
				end else if (lead != LEN_NONE && !eot) begin
					held[0] = b;
					open_len = lead;
					seen = 1;
					all_cont = 1'b1;
				end
				return;
			end
			if ((b & MASK_2) != CONT_MARK)
				all_cont = 1'b0;
			// last byte of the sequence: emit whole or drop whole
			if (seen + 1 >= int'(open_len)) begin
				if (all_cont) begin
					for (int k = 0; k < seen; k++)
						push_kept(held[k], 1'b0);
					push_kept(b, 1'b1);
				end
				drop_open();
				return;
			end
			// end of text cuts the sequence short
			if (eot) begin
				drop_open();
				return;
			end
			held[seen] = b;
			seen++;
		endfunction

		// one accepted output transaction
		function void check_out(logic [7:0] b, logic l);
			kept_byte_t want;
			if (kept.size() == 0) begin
				$error("unexpected output: out_byte %02h run_last %0b", b, l);
				fails++;
				return;
			end
			want = kept.pop_front();
			if (b !== want.data) begin
				$error("out_byte: expected %02h, actual %02h", want.data, b);
				fails++;
			end
			if (l !== want.last) begin
				$error("run_last: expected %0b, actual %0b", want.last, l);
				fails++;
			end
		endfunction

		function int outstanding();
			return kept.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] in_byte;
	logic       end_of_text;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       run_last;

	logic          steady;
	int            idle_cycles;
	kept_seq_board board;

	utf8_invalid_sequence_filter_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver side: random back-pressure, none during the steady stretch
	always @(negedge clk) begin
		out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 31);
	end

	// monitor both channels and watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.take_byte(in_byte, end_of_text);
			if (out_valid && out_ready)
				board.check_out(out_byte, run_last);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("** utf8_invalid_sequence_filter_unit: FAILED **");
				$finish;
			end
		end
	end

	// one input transaction, with a random gap ahead of it
	task automatic send_byte(input logic [7:0] b, input logic eot);
		while (!steady && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [7:0] lead_of(input int len);
		logic [7:0] r;
		r = 8'($urandom);
		case (len)
			1:       return {1'b0, r[6:0]};
			2:       return {3'b110, r[4:0]};
			3:       return {4'b1110, r[3:0]};
			default: return {5'b11110, r[2:0]};
		endcase
	endfunction

	function automatic logic [7:0] good_cont();
		logic [7:0] r;
		r = 8'($urandom);
		return {2'b10, r[5:0]};
	endfunction

	// anything but 10xxxxxx
	function automatic logic [7:0] bad_cont();
		logic [7:0] r;
		int t;
		r = 8'($urandom);
		t = $urandom_range(0, 2);
		case (t)
			0:       return {2'b00, r[5:0]};
			1:       return {2'b01, r[5:0]};
			default: return {2'b11, r[5:0]};
		endcase
	endfunction

	// mostly well-formed sequences, some with a bad continuation, some cut
	// short by end of text, and some raw noise bytes
	task automatic send_random_run(inout int sent);
		int kind;
		int len;
		int bad;
		int cut;
		int k;
		logic [7:0] b;
		kind = $urandom_range(99);
		len = $urandom_range(1, 4);
		if (kind < 25) begin
			send_byte(8'($urandom_range(255)), $urandom_range(99) < 15);
			sent++;
			return;
		end
		bad = (kind < 45 && len > 1) ? $urandom_range(1, len - 1) : 0;
		cut = (kind >= 45 && kind < 57 && len > 1) ? $urandom_range(0, len - 2) : len - 1;
		for (k = 0; k <= cut; k++) begin
			if (k == 0)
				b = lead_of(len);
			else if (k == bad)
				b = bad_cont();
			else
				b = good_cont();
			send_byte(b, (k == cut) && (cut != len - 1 || $urandom_range(99) < 20));
			sent++;
		end
	endtask

	initial begin
		int sent;
		board = new();
		idle_cycles = 0;
		steady = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_byte = 8'h00;
		end_of_text = 1'b0;
		out_ready = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// directed: zero byte, ascii top, each sequence length
		send_byte(8'h00, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'hC2, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b0);
		// invalid leads
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hF8, 1'b0);
		// bad continuation drops the pair
		send_byte(8'hC3, 1'b0);
		send_byte(8'h41, 1'b0);
		// end of text inside a sequence
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b1);
		// end of text on a lead
		send_byte(8'hC3, 1'b1);
		// end of text on the completing byte
		send_byte(8'hC3, 1'b0);
		send_byte(8'hBF, 1'b1);
		// bad continuation inside a four-byte sequence
		send_byte(8'hF4, 1'b0);
		send_byte(8'h8F, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hBF, 1'b0);

		// random part with a stretch of no idling on either side
		while (sent < RAND_ITEMS) begin
			steady = (sent >= 70 && sent < 120);
			send_random_run(sent);
		end
		steady = 1'b0;
		in_valid <= 1'b0;

		// drain the expected bytes, then give stray outputs a chance to show
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.fails == 0)
			$display("** utf8_invalid_sequence_filter_unit: PASSED **");
		else
			$display("** utf8_invalid_sequence_filter_unit: FAILED **");
		$finish;
	end

endmodule
